// ===== hdl/dfiir_pkg.sv =====
package dfiir_pkg;

   localparam int MAX_ORDER_DEF           = 20;
   localparam int SAMPLE_WIDTH_DEF        = 16;
   localparam int COEFF_FRACTION_BITS_DEF = 24;

   localparam int COEFF_W   = 32;
   localparam int TAP_IDX_W = 5;
   localparam int ORDER_W   = 5;
   localparam int ACTION_W  = 2;
   localparam int ACC_W     = 64;

   localparam logic [ORDER_W-1:0] ORDER_RESET = 5'd4;

   localparam logic [ACTION_W-1:0] ACT_SAMPLE  = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_LOAD_FF = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_LOAD_FB = 2'd2;
   localparam logic [ACTION_W-1:0] ACT_CLEAR   = 2'd3;

   localparam int CSR_AW = 3;
   localparam int CSR_DW = 32;
   localparam logic CSR_IDX_ORDER = 1'b0;

   typedef struct packed {
      logic vld;
      logic first;
      logic last;
   } term_ctrl_type;

endpackage

// ===== hdl/dfiir_coef_ram.sv =====
module dfiir_coef_ram #(
   parameter int DEPTH = 2 * dfiir_pkg::MAX_ORDER_DEF + 1,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                we,
   input  logic [AW-1:0]                       waddr,
   input  logic signed [dfiir_pkg::COEFF_W-1:0] wdata,
   input  logic [AW-1:0]                       raddr,
   output logic signed [dfiir_pkg::COEFF_W-1:0] rdata,
   output logic                                rok
);

   logic signed [dfiir_pkg::COEFF_W-1:0] mem [DEPTH];
   logic [DEPTH-1:0] valid_ff;
   logic [DEPTH-1:0] valid_in;
   logic signed [dfiir_pkg::COEFF_W-1:0] rdata_ff;
   logic rok_ff;

   always_comb begin
      valid_in = valid_ff;
      if (we) begin
         valid_in[waddr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
      rok_ff   <= valid_ff[raddr];
   end

   assign rdata = rdata_ff;
   assign rok   = rok_ff;

endmodule

// ===== hdl/dfiir_hist_ram.sv =====
module dfiir_hist_ram #(
   parameter int DEPTH        = 2 * dfiir_pkg::MAX_ORDER_DEF + 1,
   parameter int AW           = $clog2(DEPTH),
   parameter int SAMPLE_WIDTH = dfiir_pkg::SAMPLE_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic                           we,
   input  logic [AW-1:0]                  waddr,
   input  logic signed [SAMPLE_WIDTH-1:0] wdata,
   input  logic [AW-1:0]                  raddr,
   output logic signed [SAMPLE_WIDTH-1:0] rdata
);

   logic signed [SAMPLE_WIDTH-1:0] mem [DEPTH];
   logic signed [SAMPLE_WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== hdl/dfiir_mac.sv =====
module dfiir_mac #(
   parameter int SAMPLE_WIDTH        = dfiir_pkg::SAMPLE_WIDTH_DEF,
   parameter int COEFF_FRACTION_BITS = dfiir_pkg::COEFF_FRACTION_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  dfiir_pkg::term_ctrl_type             issue,
   input  logic signed [dfiir_pkg::COEFF_W-1:0] coef,
   input  logic                                 coef_ok,
   input  logic signed [SAMPLE_WIDTH-1:0]       hist,
   output logic                                 done,
   output logic signed [SAMPLE_WIDTH-1:0]       y,
   output logic                                 sat
);

   localparam int ACC_W  = dfiir_pkg::ACC_W;
   localparam int PROD_W = dfiir_pkg::COEFF_W + SAMPLE_WIDTH;
   localparam logic signed [ACC_W-1:0] HALF = ACC_W'(64'd1 << (COEFF_FRACTION_BITS - 1));
   localparam logic signed [SAMPLE_WIDTH-1:0] Y_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
   localparam logic signed [SAMPLE_WIDTH-1:0] Y_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

   function automatic logic signed [ACC_W-1:0] sat_add(
      input logic signed [ACC_W-1:0] a,
      input logic signed [ACC_W-1:0] b
   );
      logic signed [ACC_W:0] s;
      s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
      if (s[ACC_W] != s[ACC_W-1]) begin
         return s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
      end
      return s[ACC_W-1:0];
   endfunction

   dfiir_pkg::term_ctrl_type s1_ff, s1_in;
   dfiir_pkg::term_ctrl_type s2_ff, s2_in;
   logic s3_ff, s3_in;
   logic done_ff, done_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic signed [ACC_W-1:0] rnd_ff, rnd_in;
   logic signed [ACC_W-1:0] prod_ext;
   logic signed [ACC_W-1:0] acc_base;
   logic signed [ACC_W-1:0] shifted;

   always_comb begin
      s1_in    = issue;
      s2_in    = s1_ff;
      s3_in    = s2_ff.vld && s2_ff.last;
      done_in  = s3_ff;
      prod_in  = coef_ok ? PROD_W'(coef * hist) : '0;
      prod_ext = ACC_W'(prod_ff);
      acc_base = s2_ff.first ? '0 : acc_ff;
      acc_in   = s2_ff.vld ? sat_add(acc_base, prod_ext) : acc_ff;
      rnd_in   = s3_ff ? sat_add(acc_ff, HALF) : rnd_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff   <= '0;
         s2_ff   <= '0;
         s3_ff   <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         s1_ff   <= s1_in;
         s2_ff   <= s2_in;
         s3_ff   <= s3_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      rnd_ff  <= rnd_in;
   end

   // floor shift, then clip to the sample range
   always_comb begin
      shifted = rnd_ff >>> COEFF_FRACTION_BITS;
      y       = shifted[SAMPLE_WIDTH-1:0];
      sat     = 1'b0;
      if (!shifted[ACC_W-1] && (|shifted[ACC_W-2:SAMPLE_WIDTH-1])) begin
         y   = Y_MAX;
         sat = 1'b1;
      end else if (shifted[ACC_W-1] && !(&shifted[ACC_W-2:SAMPLE_WIDTH-1])) begin
         y   = Y_MIN;
         sat = 1'b1;
      end
   end

   assign done = done_ff;

   a_done_after_last: assert property (@(posedge clock) disable iff (reset)
      s2_ff.vld && s2_ff.last |=> ##1 done_ff)
      else $error("mac done did not follow the last term");

   a_first_leads: assert property (@(posedge clock) disable iff (reset)
      s2_ff.vld && s2_ff.first |-> !s3_ff)
      else $error("new accumulation started while rounding");

   a_no_issue_in_round: assert property (@(posedge clock) disable iff (reset)
      s3_ff |-> !s2_ff.vld)
      else $error("term still in flight at rounding");

endmodule

// ===== hdl/direct_form_iir_filter_core.sv =====
// Direct-form I IIR filter core.
// Request channel (req_valid / req_stall): each request carries an action.
//   Sample: filter req_sample_in and return one response.
//   Load feedforward / feedback tap: write req_coefficient at req_tap_index.
//   Clear: restart the signal (sample count, so warm-up refills the histories); taps are kept.
// Response channel (rsp_valid / rsp_stall): rsp_sample_out, rsp_saturated,
//   one per sample request, in order. Loads and clears give no response.
// CSR port (APB style, pready always high): filter_order at byte offset 0.
//   Write it only while the core is idle.
// Flow: a filtered sample runs one shared multiply-accumulate over the
//   2*order+1 taps, one tap per cycle from the tap and history RAMs; the
//   next request is taken in the same cycle that its response shows. Warm-up
//   samples (the first order+1 of a signal) skip the accumulation and go
//   straight to write-back with a zero output; loads and clears leave the core
//   idle.
// A finished response waits in an output register; while rsp_stall holds it,
//   loads, clears and the next sample's work still proceed, and only the
//   write-back of the following sample waits.
// Reset (synchronous): order 4, all taps zero, empty history, no response.
module direct_form_iir_filter_core #(
   parameter int MAX_ORDER           = dfiir_pkg::MAX_ORDER_DEF,
   parameter int SAMPLE_WIDTH        = dfiir_pkg::SAMPLE_WIDTH_DEF,
   parameter int COEFF_FRACTION_BITS = dfiir_pkg::COEFF_FRACTION_BITS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [dfiir_pkg::ACTION_W-1:0]         req_action,
   input  logic [dfiir_pkg::TAP_IDX_W-1:0]        req_tap_index,
   input  logic signed [dfiir_pkg::COEFF_W-1:0]   req_coefficient,
   input  logic signed [SAMPLE_WIDTH-1:0]         req_sample_in,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [SAMPLE_WIDTH-1:0]         rsp_sample_out,
   output logic                                   rsp_saturated,
   input  logic                                   csr_psel,
   input  logic                                   csr_penable,
   input  logic                                   csr_pwrite,
   input  logic [dfiir_pkg::CSR_AW-1:0]           csr_paddr,
   input  logic [dfiir_pkg::CSR_DW-1:0]           csr_pwdata,
   output logic [dfiir_pkg::CSR_DW-1:0]           csr_prdata,
   output logic                                   csr_pready
);

   localparam int N_IN   = MAX_ORDER + 1;
   localparam int DEPTH  = 2 * MAX_ORDER + 1;
   localparam int AW     = $clog2(DEPTH);
   localparam int IN_PW  = $clog2(MAX_ORDER + 1);
   localparam int OUT_PW = $clog2(MAX_ORDER);
   localparam int ORD_W  = $clog2(MAX_ORDER + 1);
   localparam int CNT_W  = $clog2(MAX_ORDER + 2);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_WAIT = 2'd2;
   localparam logic [1:0] ST_WB   = 2'd3;

   logic [1:0] state_ff, state_in;
   logic [dfiir_pkg::ORDER_W-1:0] order_ff, order_in;
   logic [ORD_W-1:0] ord_ff, ord_in;
   logic [ORD_W-1:0] k_ff, k_in;
   logic fb_ff, fb_in;
   logic warm_ff, warm_in;
   logic [IN_PW-1:0] in_head_ff, in_head_in;
   logic [IN_PW-1:0] in_ptr_ff, in_ptr_in;
   logic [OUT_PW-1:0] out_head_ff, out_head_in;
   logic [OUT_PW-1:0] out_ptr_ff, out_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_WIDTH-1:0] rsp_sample_out_ff, rsp_sample_out_in;
   logic rsp_saturated_ff, rsp_saturated_in;

   logic accept;
   logic accept_sample;
   logic wb_go;
   logic warm_now;
   logic [ORD_W-1:0] ord_eff;
   logic [IN_PW-1:0] in_head_nxt;
   logic [OUT_PW-1:0] out_head_nxt;
   logic term_last;
   logic ff_ok;
   logic fb_ok;
   logic csr_write;

   dfiir_pkg::term_ctrl_type issue;

   logic hist_we;
   logic [AW-1:0] hist_waddr;
   logic signed [SAMPLE_WIDTH-1:0] hist_wdata;
   logic [AW-1:0] hist_raddr;
   logic signed [SAMPLE_WIDTH-1:0] hist_rdata;

   logic coef_we;
   logic [AW-1:0] coef_waddr;
   logic [AW-1:0] coef_raddr;
   logic signed [dfiir_pkg::COEFF_W-1:0] coef_rdata;
   logic coef_rok;

   logic mac_done;
   logic signed [SAMPLE_WIDTH-1:0] mac_y;
   logic mac_sat;
   logic signed [SAMPLE_WIDTH-1:0] y_wb;
   logic sat_wb;

   assign req_stall     = (state_ff != ST_IDLE);
   assign accept        = req_valid && !req_stall;
   assign accept_sample = accept && (req_action == dfiir_pkg::ACT_SAMPLE);
   assign wb_go         = (state_ff == ST_WB) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      if (order_ff == '0) begin
         ord_eff = ORD_W'(1);
      end else if (32'(order_ff) > MAX_ORDER) begin
         ord_eff = ORD_W'(MAX_ORDER);
      end else begin
         ord_eff = ORD_W'(order_ff);
      end
   end

   assign warm_now     = (count_ff <= CNT_W'(ord_eff));
   assign in_head_nxt  = (in_head_ff == IN_PW'(MAX_ORDER)) ? '0 : in_head_ff + IN_PW'(1);
   assign out_head_nxt = (out_head_ff == OUT_PW'(MAX_ORDER - 1)) ? '0
                                                                 : out_head_ff + OUT_PW'(1);
   assign term_last    = fb_ff && (k_ff == ord_ff - ORD_W'(1));

   assign issue.vld   = (state_ff == ST_RUN);
   assign issue.first = !fb_ff && (k_ff == '0);
   assign issue.last  = term_last;

   assign y_wb   = warm_ff ? '0 : mac_y;
   assign sat_wb = warm_ff ? 1'b0 : mac_sat;

   always_comb begin
      state_in          = state_ff;
      ord_in            = ord_ff;
      k_in              = k_ff;
      fb_in             = fb_ff;
      warm_in           = warm_ff;
      in_head_in        = in_head_ff;
      in_ptr_in         = in_ptr_ff;
      out_head_in       = out_head_ff;
      out_ptr_in        = out_ptr_ff;
      count_in          = count_ff;
      rsp_valid_in      = rsp_valid_ff;
      rsp_sample_out_in = rsp_sample_out_ff;
      rsp_saturated_in  = rsp_saturated_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept_sample) begin
               in_head_in = in_head_nxt;
               in_ptr_in  = in_head_nxt;
               out_ptr_in = out_head_ff;
               k_in       = '0;
               fb_in      = 1'b0;
               ord_in     = ord_eff;
               warm_in    = warm_now;
               if (count_ff != CNT_W'(MAX_ORDER + 1)) begin
                  count_in = count_ff + CNT_W'(1);
               end
               state_in = warm_now ? ST_WB : ST_RUN;
            end else if (accept && (req_action == dfiir_pkg::ACT_CLEAR)) begin
               count_in = '0;
            end
         end
         ST_RUN: begin
            if (!fb_ff) begin
               in_ptr_in = (in_ptr_ff == '0) ? IN_PW'(MAX_ORDER) : in_ptr_ff - IN_PW'(1);
               if (k_ff == ord_ff) begin
                  fb_in = 1'b1;
                  k_in  = '0;
               end else begin
                  k_in = k_ff + ORD_W'(1);
               end
            end else if (term_last) begin
               state_in = ST_WAIT;
            end else begin
               k_in       = k_ff + ORD_W'(1);
               out_ptr_in = (out_ptr_ff == '0) ? OUT_PW'(MAX_ORDER - 1)
                                               : out_ptr_ff - OUT_PW'(1);
            end
         end
         ST_WAIT: begin
            if (mac_done) begin
               state_in = ST_WB;
            end
         end
         ST_WB: begin
            if (wb_go) begin
               out_head_in       = out_head_nxt;
               rsp_valid_in      = 1'b1;
               rsp_sample_out_in = y_wb;
               rsp_saturated_in  = sat_wb;
               state_in          = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // CSR
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == dfiir_pkg::CSR_IDX_ORDER) ?
                       dfiir_pkg::CSR_DW'(order_ff) : '0;

   always_comb begin
      order_in = order_ff;
      if (csr_write && (csr_paddr[2] == dfiir_pkg::CSR_IDX_ORDER)) begin
         order_in = csr_pwdata[dfiir_pkg::ORDER_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         order_ff     <= dfiir_pkg::ORDER_RESET;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         in_head_ff   <= '0;
         out_head_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         order_ff     <= order_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         in_head_ff   <= in_head_in;
         out_head_ff  <= out_head_in;
      end
   end

   always_ff @(posedge clock) begin
      ord_ff            <= ord_in;
      k_ff              <= k_in;
      fb_ff             <= fb_in;
      warm_ff           <= warm_in;
      in_ptr_ff         <= in_ptr_in;
      out_ptr_ff        <= out_ptr_in;
      rsp_sample_out_ff <= rsp_sample_out_in;
      rsp_saturated_ff  <= rsp_saturated_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_out_ff;
   assign rsp_saturated  = rsp_saturated_ff;

   // history RAM: inputs at 0..MAX_ORDER, outputs above
   assign hist_we    = accept_sample || wb_go;
   assign hist_waddr = wb_go ? AW'(N_IN) + AW'(out_head_nxt) : AW'(in_head_nxt);
   assign hist_wdata = wb_go ? y_wb : req_sample_in;
   assign hist_raddr = fb_ff ? AW'(N_IN) + AW'(out_ptr_ff) : AW'(in_ptr_ff);

   // tap RAM: a[0..MAX_ORDER] then b[1..MAX_ORDER]
   assign ff_ok      = (32'(req_tap_index) <= MAX_ORDER);
   assign fb_ok      = (req_tap_index != '0) && (32'(req_tap_index) <= MAX_ORDER);
   assign coef_we    = accept && (((req_action == dfiir_pkg::ACT_LOAD_FF) && ff_ok) ||
                                  ((req_action == dfiir_pkg::ACT_LOAD_FB) && fb_ok));
   assign coef_waddr = (req_action == dfiir_pkg::ACT_LOAD_FB) ?
                       AW'(N_IN) + AW'(req_tap_index - 5'd1) : AW'(req_tap_index);
   assign coef_raddr = fb_ff ? AW'(N_IN) + AW'(k_ff) : AW'(k_ff);

   dfiir_hist_ram #(
      .DEPTH        (DEPTH),
      .AW           (AW),
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_hist (
      .clock (clock),
      .we    (hist_we),
      .waddr (hist_waddr),
      .wdata (hist_wdata),
      .raddr (hist_raddr),
      .rdata (hist_rdata)
   );

   dfiir_coef_ram #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_coef (
      .clock (clock),
      .reset (reset),
      .we    (coef_we),
      .waddr (coef_waddr),
      .wdata (req_coefficient),
      .raddr (coef_raddr),
      .rdata (coef_rdata),
      .rok   (coef_rok)
   );

   dfiir_mac #(
      .SAMPLE_WIDTH        (SAMPLE_WIDTH),
      .COEFF_FRACTION_BITS (COEFF_FRACTION_BITS)
   ) u_mac (
      .clock   (clock),
      .reset   (reset),
      .issue   (issue),
      .coef    (coef_rdata),
      .coef_ok (coef_rok),
      .hist    (hist_rdata),
      .done    (mac_done),
      .y       (mac_y),
      .sat     (mac_sat)
   );

   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      mac_done |-> (state_ff == ST_WAIT))
      else $error("mac result arrived outside the wait state");

   a_no_write_during_mac: assert property (@(posedge clock) disable iff (reset)
      hist_we |-> (state_ff != ST_RUN) && (state_ff != ST_WAIT))
      else $error("history written while taps are being read");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_ORDER + 1))
      else $error("sample count past saturation");

   a_filter_runs: assert property (@(posedge clock) disable iff (reset)
      accept_sample && !warm_now |=> (state_ff == ST_RUN))
      else $error("filtered sample did not start the accumulation");

   a_wb_loads_rsp: assert property (@(posedge clock) disable iff (reset)
      wb_go |=> rsp_valid_ff && (state_ff == ST_IDLE))
      else $error("write-back did not present a response");

endmodule
